### design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Holds the list geometry, the opcode and status codes, the sequencer states
// and the request bundle that the controller hands to the element memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

endpackage

### design/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram: simple dual-port element memory
// One write port and one read port; read data is registered and holds its
// value until the next read is enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ils_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl: list sequencer and result register
// Decodes one beat, checks it against the element count, drives the memory
// for reads, writes and the one-per-cycle shifts of insert and remove, and
// stages the result in an output register that parts the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ils_pkg::OP_W-1:0]           s_opcode,
    input  logic [ils_pkg::POS_W-1:0]          s_position,
    input  logic signed [ils_pkg::WORD_W-1:0]  s_word_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ils_pkg::WORD_W-1:0]  m_word_out,
    output logic [ils_pkg::COUNT_W-1:0]        m_count_after,
    output logic [ils_pkg::STATUS_W-1:0]       m_status,
    output ils_pkg::mem_req_t                  mem_req,
    input  logic [ils_pkg::WORD_W-1:0]         mem_rdata
);

    ils_pkg::state_t                   state_reg, state_next;
    logic [ils_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [ils_pkg::ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [ils_pkg::ADDR_W-1:0]        end_reg, end_next;
    logic [ils_pkg::WORD_W-1:0]        word_reg, word_next;
    logic                              is_get_reg, is_get_next;
    ils_pkg::status_t                  status_reg, status_next;
    logic                              m_valid_reg, m_valid_next;
    logic [ils_pkg::WORD_W-1:0]        m_word_reg, m_word_next;
    logic [ils_pkg::COUNT_W-1:0]       m_count_reg, m_count_next;
    ils_pkg::status_t                  m_status_reg, m_status_next;

    ils_pkg::opcode_t                  op;
    logic                              in_range;
    logic                              full;
    logic [ils_pkg::COUNT_W-1:0]       count_m1;
    logic [ils_pkg::ADDR_W-1:0]        pos_addr;
    logic [ils_pkg::ADDR_W-1:0]        last_addr;
    logic                              out_free;
    logic                              load_out;

    assign op        = ils_pkg::opcode_t'(s_opcode);
    assign in_range  = ils_pkg::COUNT_W'(s_position) < count_reg;
    assign full      = count_reg == ils_pkg::COUNT_W'(ils_pkg::CAPACITY);
    assign count_m1  = count_reg - ils_pkg::COUNT_W'(1);
    assign pos_addr  = ils_pkg::ADDR_W'(s_position);
    assign last_addr = count_m1[ils_pkg::ADDR_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ils_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (op == ils_pkg::OP_INSERT && in_range && !full) begin
                        state_next = ils_pkg::S_SHIFT_UP;
                    end else if (op == ils_pkg::OP_REMOVE && in_range &&
                                 pos_addr != last_addr) begin
                        state_next = ils_pkg::S_SHIFT_DN;
                    end else begin
                        state_next = ils_pkg::S_DONE;
                    end
                end
            end
            ils_pkg::S_SHIFT_UP: begin
                if (ptr_reg == end_reg) begin
                    state_next = ils_pkg::S_INS_WR;
                end
            end
            ils_pkg::S_INS_WR: begin
                state_next = ils_pkg::S_DONE;
            end
            ils_pkg::S_SHIFT_DN: begin
                if (ptr_reg == end_reg) begin
                    state_next = ils_pkg::S_DONE;
                end
            end
            ils_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            default: state_next = ils_pkg::S_IDLE;
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        mem_req      = '0;
        s_ready      = 1'b0;
        load_out     = 1'b0;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        word_next    = word_reg;
        is_get_next  = is_get_reg;
        status_next  = status_reg;

        unique case (state_reg)
            ils_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    is_get_next = 1'b0;
                    status_next = ils_pkg::ST_OK;
                    unique case (op)
                        ils_pkg::OP_GET: begin
                            if (in_range) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pos_addr;
                                is_get_next     = 1'b1;
                            end else begin
                                status_next = ils_pkg::ST_BAD_INDEX;
                            end
                        end
                        ils_pkg::OP_SET: begin
                            if (in_range) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = pos_addr;
                                mem_req.wr_data = s_word_in;
                            end else begin
                                status_next = ils_pkg::ST_BAD_INDEX;
                            end
                        end
                        ils_pkg::OP_APPEND: begin
                            if (full) begin
                                status_next = ils_pkg::ST_FULL;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = count_reg[ils_pkg::ADDR_W-1:0];
                                mem_req.wr_data = s_word_in;
                                count_next      = count_reg + ils_pkg::COUNT_W'(1);
                            end
                        end
                        ils_pkg::OP_INSERT: begin
                            if (!in_range) begin
                                status_next = ils_pkg::ST_BAD_INDEX;
                            end else if (full) begin
                                status_next = ils_pkg::ST_FULL;
                            end else begin
                                // Move the tail up, starting from the last element.
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = last_addr;
                                ptr_next        = last_addr;
                                end_next        = pos_addr;
                                word_next       = s_word_in;
                                count_next      = count_reg + ils_pkg::COUNT_W'(1);
                            end
                        end
                        ils_pkg::OP_REMOVE: begin
                            if (!in_range) begin
                                status_next = ils_pkg::ST_BAD_INDEX;
                            end else begin
                                count_next = count_m1;
                                if (pos_addr != last_addr) begin
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = pos_addr + ils_pkg::ADDR_W'(1);
                                    ptr_next        = pos_addr + ils_pkg::ADDR_W'(1);
                                    end_next        = last_addr;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ils_pkg::S_SHIFT_UP: begin
                // Data read last cycle from ptr lands one slot higher.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg + ils_pkg::ADDR_W'(1);
                mem_req.wr_data = mem_rdata;
                if (ptr_reg != end_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg - ils_pkg::ADDR_W'(1);
                    ptr_next        = ptr_reg - ils_pkg::ADDR_W'(1);
                end
            end
            ils_pkg::S_INS_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = end_reg;
                mem_req.wr_data = word_reg;
            end
            ils_pkg::S_SHIFT_DN: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg - ils_pkg::ADDR_W'(1);
                mem_req.wr_data = mem_rdata;
                if (ptr_reg != end_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg + ils_pkg::ADDR_W'(1);
                    ptr_next        = ptr_reg + ils_pkg::ADDR_W'(1);
                end
            end
            ils_pkg::S_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // Result register; the memory read data holds through the done state.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;
        m_count_next  = m_count_reg;
        m_status_next = m_status_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_word_next   = is_get_reg ? mem_rdata : '0;
            m_count_next  = count_reg;
            m_status_next = status_reg;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ils_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        word_reg     <= word_next;
        is_get_reg   <= is_get_next;
        status_reg   <= status_next;
        m_word_reg   <= m_word_next;
        m_count_reg  <= m_count_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_word_out    = m_word_reg;
    assign m_count_after = m_count_reg;
    assign m_status      = m_status_reg;

endmodule

### design/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core: fixed-capacity ordered list of signed words
// Get, set, append, insert-before and remove on a list held in one memory.
//
//   Channel   Direction  Ports                                  Beat
//   s_        in         s_opcode, s_position, s_word_in        one operation
//   m_        out        m_word_out, m_count_after, m_status    one result
//
// Get, set, append, out-of-range and full cases go straight to S_DONE. Insert
// at position p of a list of n moves the n - p elements from p up, then
// writes the new word; remove moves the n - p - 1 elements above p down;
// the single write port moves one element per cycle. Reset clears state,
// count and result valid; the memory is not swept and needs no clearing pass.
// A new beat is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_store_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ils_pkg::OP_W-1:0]           s_opcode,
    input  logic [ils_pkg::POS_W-1:0]          s_position,
    input  logic signed [ils_pkg::WORD_W-1:0]  s_word_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ils_pkg::WORD_W-1:0]  m_word_out,
    output logic [ils_pkg::COUNT_W-1:0]        m_count_after,
    output logic [ils_pkg::STATUS_W-1:0]       m_status
);

    ils_pkg::mem_req_t           mem_req;
    logic [ils_pkg::WORD_W-1:0]  mem_rdata;

    ils_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_position    (s_position),
        .s_word_in     (s_word_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word_out    (m_word_out),
        .m_count_after (m_count_after),
        .m_status      (m_status),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    ils_ram #(
        .DATA_W (ils_pkg::WORD_W),
        .DEPTH  (ils_pkg::CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rdata)
    );

endmodule

### design/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the result channel for consistency between count, status and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ils_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [ils_pkg::WORD_W-1:0]  m_word_out,
    input logic [ils_pkg::COUNT_W-1:0]        m_count_after,
    input logic [ils_pkg::STATUS_W-1:0]       m_status
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_out) &&
        $stable(m_count_after) && $stable(m_status))
        else $error("result beat changed while stalled");

    // A full error is only possible at capacity.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ils_pkg::ST_FULL |->
        m_count_after == ils_pkg::COUNT_W'(ils_pkg::CAPACITY))
        else $error("full status below capacity");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count_after <= ils_pkg::COUNT_W'(ils_pkg::CAPACITY))
        else $error("count above capacity");

    // Only a successful get returns data.
    a_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_out != '0 |-> m_status == ils_pkg::ST_OK &&
        m_count_after != '0)
        else $error("data returned with an error status or empty list");

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_word_out    (m_word_out),
    .m_count_after (m_count_after),
    .m_status      (m_status)
);
